// ===== hw/rtl/bfba_pkg.sv =====
// Shared types and constants of the best-fit block allocator.
`default_nettype none
package bfba_pkg;

  localparam int BYTES_W = 21;   // segment data size
  localparam int START_W = 21;   // segment header offset
  localparam int END_W   = 22;   // start + header + size
  localparam int SIZE_W  = 22;   // rounded request size

  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_INIT    = 3'd1;
  localparam logic [2:0] OP_TAKE    = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_SPLIT   = 3'd4;
  localparam logic [2:0] OP_MERGE   = 3'd5;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_NO_FIT   = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [BYTES_W-1:0] bytes;
    logic               free;
  } entry_t;

  // search word travelling down the chain
  typedef struct packed {
    logic               valid;
    logic               found;
    logic               rm_pend;   // next cell decides the right merge
    logic               lm;        // left neighbour free and adjacent
    logic               rm;        // right neighbour free and adjacent
    logic [BYTES_W-1:0] best_bytes;
    logic [START_W-1:0] best_start;
    logic [END_W-1:0]   prev_end;
    logic               prev_free;
  } token_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [SIZE_W-1:0] val;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfba_if.sv =====
// Handshake channels for allocator requests and responses.
`default_nettype none
interface bfba_req_if #(parameter int ADDR_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [20:0]          request_bytes;
  logic [ADDR_BITS-1:0] block_address;
  modport source (output valid, kind, request_bytes, block_address, input ready);
  modport sink   (input valid, kind, request_bytes, block_address, output ready);
endinterface

interface bfba_rsp_if #(parameter int ADDR_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] address;
  logic [20:0]          granted_bytes;
  modport source (output valid, status, address, granted_bytes, input ready);
  modport sink   (input valid, status, address, granted_bytes, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bfba_cell.sv =====
// One segment cell: holds an entry, updates the search word, applies table commands.
`default_nettype none
module bfba_cell #(
  parameter int IDX          = 0,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 20
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire  bfba_pkg::token_t                      tok_in,
  input  wire  [$clog2(MAX_SEGMENTS)-1:0]             bidx_in,
  output bfba_pkg::token_t                            tok_out,
  output logic [$clog2(MAX_SEGMENTS)-1:0]             bidx_out,
  input  wire  bfba_pkg::cmd_t                        cmd,
  input  wire  [$clog2(MAX_SEGMENTS)-1:0]             cmd_idx,
  input  wire                                         op_free,
  input  wire  [bfba_pkg::SIZE_W-1:0]                 size,
  input  wire  [ADDR_BITS-1:0]                        addr,
  input  wire  [$clog2(MAX_SEGMENTS+1)-1:0]           count,
  input  wire  bfba_pkg::entry_t                      left,
  input  wire  bfba_pkg::entry_t                      right,
  output bfba_pkg::entry_t                            ent
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [IW:0] MY = (IW+1)'(IDX);

  bfba_pkg::token_t          t;
  logic [IW-1:0]             b;
  logic                      live;
  logic [bfba_pkg::END_W-1:0] ent_end;
  logic                      hit;
  logic [IW:0]               ci;
  logic [IW:0]               ci1;

  assign live    = 32'(IDX) < 32'(count);
  assign ent_end = bfba_pkg::END_W'(ent.start) + bfba_pkg::END_W'(HEADER_BYTES)
                 + bfba_pkg::END_W'(ent.bytes);
  assign hit     = (33'(ent.start) + 33'(HEADER_BYTES)) == 33'(addr);
  assign ci      = {1'b0, cmd_idx};
  assign ci1     = ci + 1'b1;

  always_comb begin
    t = tok_in;
    b = bidx_in;
    if (!op_free) begin
      if (live && ent.free && bfba_pkg::SIZE_W'(ent.bytes) >= size &&
          (!tok_in.found || ent.bytes < tok_in.best_bytes)) begin
        t.found      = 1'b1;
        t.best_bytes = ent.bytes;
        t.best_start = ent.start;
        b            = IW'(IDX);
      end
    end else begin
      if (tok_in.rm_pend) begin
        t.rm      = live && ent.free && tok_in.prev_end == bfba_pkg::END_W'(ent.start);
        t.rm_pend = 1'b0;
      end
      if (!tok_in.found && live && !ent.free && hit) begin
        t.found   = 1'b1;
        t.lm      = tok_in.prev_free && tok_in.prev_end == bfba_pkg::END_W'(ent.start);
        t.rm_pend = 1'b1;
        b         = IW'(IDX);
      end
    end
    t.prev_end  = ent_end;
    t.prev_free = ent.free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out  <= t;
      bidx_out <= b;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bfba_pkg::OP_INIT: begin
        ent.start <= '0;
        ent.bytes <= (IDX == 0) ? bfba_pkg::BYTES_W'(cmd.val) : '0;
        ent.free  <= (IDX == 0);
      end
      bfba_pkg::OP_TAKE: begin
        if (MY == ci) ent.free <= 1'b0;
      end
      bfba_pkg::OP_RELEASE: begin
        if (MY == ci) ent.free <= 1'b1;
      end
      bfba_pkg::OP_SPLIT: begin
        if (MY == ci) begin
          ent.bytes <= bfba_pkg::BYTES_W'(cmd.val);
          ent.free  <= 1'b0;
        end else if (MY == ci1) begin
          ent.start <= bfba_pkg::START_W'(bfba_pkg::SIZE_W'(left.start)
                       + bfba_pkg::SIZE_W'(HEADER_BYTES) + cmd.val);
          ent.bytes <= bfba_pkg::BYTES_W'(bfba_pkg::SIZE_W'(left.bytes) - cmd.val
                       - bfba_pkg::SIZE_W'(HEADER_BYTES));
          ent.free  <= 1'b1;
        end else if (MY > ci1) begin
          ent <= left;
        end
      end
      bfba_pkg::OP_MERGE: begin
        if (MY == ci) begin
          ent.bytes <= ent.bytes + bfba_pkg::BYTES_W'(HEADER_BYTES) + right.bytes;
        end else if (MY > ci) begin
          ent <= right;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator: sequencer, size rounding and segment chain.
//
// Usage: requests arrive on the "request" channel (kind, request_bytes,
// block_address); one response word per request leaves on "response"
// (status, address, granted_bytes). Both are valid/ready channels; a word
// moves at a clock edge with valid and ready high.
// The segment table lives in a chain of MAX_SEGMENTS cells, one segment
// each. A search word walks the chain one cell per cycle, through every
// cell, for each request but a zero-size allocate. An allocate first rounds
// its size with a reciprocal multiply and then a multiply by the granule.
// One request is in work at a time; the next is taken only once the
// response of the last has been loaded into the output register.
// The response sits in an output register; a stalled receiver holds it and
// blocks the next result, while a new request may still be taken in.
// Writing arena_size (cfg_write_en/cfg_write_data) clamps the value and
// rebuilds the table as one free segment; write only when idle.
// Reset (rst, synchronous) restores a 65536-byte arena; the table is built
// in the first cycles after reset, before the first scan.
`default_nettype none
module best_fit_block_allocator #(
  parameter int MAX_SEGMENTS  = 64,
  parameter int HEADER_BYTES  = 24,
  parameter int GRANULE_BYTES = 16,
  parameter int ADDR_BITS     = 20
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write_en,
  input  wire  [20:0] cfg_write_data,
  bfba_req_if.sink    request,
  bfba_rsp_if.source  response
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int GL = $clog2(GRANULE_BYTES);
  // reciprocal of the granule, exact for every dividend below 2^SIZE_W
  localparam int RW = bfba_pkg::SIZE_W + 2;
  localparam int QW = bfba_pkg::SIZE_W + RW;
  localparam logic [63:0] RECIP =
    ((64'd1 << (bfba_pkg::SIZE_W + GL)) + 64'(GRANULE_BYTES - 1)) / 64'(GRANULE_BYTES);
  localparam int PW = bfba_pkg::SIZE_W + GL + 1;
  localparam logic [21:0] ARENA_TOP =
    (ADDR_BITS >= 20) ? 22'd1048576 : 22'(64'd1 << ADDR_BITS);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SCAN0 = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_RMRG  = 4'd6;
  localparam logic [3:0] S_LMRG  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                   state;
  logic [20:0]                  arena;
  logic [CW-1:0]                count;
  bfba_pkg::cmd_t               cmd;
  logic [IW-1:0]                cmd_idx;
  logic [2:0]                   op_next;

  // latched request
  logic                         kind;
  logic [bfba_pkg::SIZE_W-1:0]  dq;      // request plus granule - 1, then quotient
  logic [bfba_pkg::SIZE_W-1:0]  size;
  logic [ADDR_BITS-1:0]         addr;

  // pending result
  logic [1:0]                   res_status;
  logic [ADDR_BITS-1:0]         res_address;
  logic [20:0]                  res_bytes;
  logic                         lm;
  logic                         rm;
  logic [IW-1:0]                hit_idx;

  // chain
  bfba_pkg::token_t             tok  [MAX_SEGMENTS+1];
  logic [IW-1:0]                bidx [MAX_SEGMENTS+1];
  bfba_pkg::entry_t             ents [MAX_SEGMENTS];

  logic [21:0]                  wr_clamped;
  logic [QW-1:0]                qprod;
  logic [bfba_pkg::SIZE_W-1:0]  quot;
  logic [PW-1:0]                prod;
  logic [bfba_pkg::SIZE_W-1:0]  remain;
  logic                         do_split;
  logic [31:0]                  data_off;
  bfba_pkg::token_t             last;
  logic [IW-1:0]                last_idx;

  assign request.ready = (state == S_IDLE);

  // clamp of the written arena size
  always_comb begin
    wr_clamped = {1'b0, cfg_write_data};
    if (wr_clamped < 22'd64)   wr_clamped = 22'd64;
    if (wr_clamped > ARENA_TOP) wr_clamped = ARENA_TOP;
  end

  // round up: quotient by reciprocal, then back to bytes
  assign qprod = QW'(dq) * QW'(RECIP[RW-1:0]);
  assign quot  = bfba_pkg::SIZE_W'(qprod >> (bfba_pkg::SIZE_W + GL));
  assign prod  = PW'(dq) * PW'(GRANULE_BYTES);

  assign last     = tok[MAX_SEGMENTS];
  assign last_idx = bidx[MAX_SEGMENTS];
  assign remain   = bfba_pkg::SIZE_W'(last.best_bytes) - size;
  assign do_split = remain >= bfba_pkg::SIZE_W'(HEADER_BYTES + GRANULE_BYTES)
                    && count < MAX_CNT;
  assign data_off = 32'(last.best_start) + 32'(HEADER_BYTES);

  // search word entering the chain
  assign tok[0]  = bfba_pkg::token_t'({(state == S_SCAN0),
                                        {($bits(bfba_pkg::token_t) - 1){1'b0}}});
  assign bidx[0] = '0;

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    bfba_pkg::entry_t lft;
    bfba_pkg::entry_t rgt;
    if (g == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_ln
      assign lft = ents[g-1];
    end
    if (g == MAX_SEGMENTS - 1) begin : g_rl
      assign rgt = '0;
    end else begin : g_rn
      assign rgt = ents[g+1];
    end
    bfba_cell #(
      .IDX(g), .HEADER_BYTES(HEADER_BYTES),
      .MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk(clk), .rst(rst),
      .tok_in(tok[g]), .bidx_in(bidx[g]),
      .tok_out(tok[g+1]), .bidx_out(bidx[g+1]),
      .cmd(cmd), .cmd_idx(cmd_idx),
      .op_free(kind), .size(size), .addr(addr), .count(count),
      .left(lft), .right(rgt), .ent(ents[g])
    );
  end

  // table command issued at the end of this cycle
  always_comb begin
    op_next = bfba_pkg::OP_NOP;
    if (!cfg_write_en) begin
      case (state)
        S_INIT: begin
          op_next = bfba_pkg::OP_INIT;
        end
        S_SCAN: begin
          if (last.valid && last.found) begin
            if (kind == bfba_pkg::KIND_ALLOC)
              op_next = do_split ? bfba_pkg::OP_SPLIT : bfba_pkg::OP_TAKE;
            else
              op_next = bfba_pkg::OP_RELEASE;
          end
        end
        S_RMRG: begin
          if (rm) op_next = bfba_pkg::OP_MERGE;
        end
        S_LMRG: begin
          if (lm) op_next = bfba_pkg::OP_MERGE;
        end
        default: begin
          op_next = bfba_pkg::OP_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INIT;
      arena          <= 21'd65536;
      count          <= CW'(1);
      cmd.op         <= bfba_pkg::OP_NOP;
      response.valid <= 1'b0;
    end else begin
      cmd.op <= op_next;
      if (response.valid && response.ready && (cfg_write_en || state != S_OUT))
        response.valid <= 1'b0;
      if (cfg_write_en) begin
        arena <= wr_clamped[20:0];
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            cmd.val <= (arena >= 21'(HEADER_BYTES))
                       ? bfba_pkg::SIZE_W'(arena - 21'(HEADER_BYTES)) : '0;
            count   <= CW'(1);
            state   <= S_IDLE;
          end
          S_IDLE: begin
            if (request.valid) begin
              kind <= request.kind;
              addr <= request.block_address;
              dq   <= bfba_pkg::SIZE_W'(request.request_bytes)
                      + bfba_pkg::SIZE_W'(GRANULE_BYTES - 1);
              res_status  <= (request.kind == bfba_pkg::KIND_ALLOC &&
                              request.request_bytes == 21'd0)
                             ? bfba_pkg::ST_ZERO : bfba_pkg::ST_OK;
              res_address <= '0;
              res_bytes   <= '0;
              if (request.kind == bfba_pkg::KIND_FREE) begin
                state <= S_SCAN0;
              end else if (request.request_bytes == 21'd0) begin
                state <= S_OUT;
              end else begin
                state <= S_DIV;
              end
            end
          end
          S_DIV: begin
            dq    <= quot;
            state <= S_MUL;
          end
          S_MUL: begin
            size  <= prod[bfba_pkg::SIZE_W-1:0];
            state <= S_SCAN0;
          end
          S_SCAN0: begin
            state <= S_SCAN;
          end
          S_SCAN: begin
            if (last.valid) begin
              cmd_idx <= last_idx;
              hit_idx <= last_idx;
              lm      <= last.lm;
              rm      <= last.rm;
              if (kind == bfba_pkg::KIND_ALLOC) begin
                state <= S_OUT;
                if (!last.found) begin
                  res_status <= bfba_pkg::ST_NO_FIT;
                end else begin
                  res_address <= data_off[ADDR_BITS-1:0];
                  if (do_split) begin
                    cmd.val   <= size;
                    count     <= count + CW'(1);
                    res_bytes <= size[20:0];
                  end else begin
                    res_bytes <= last.best_bytes;
                  end
                end
              end else begin
                if (!last.found) begin
                  res_status <= bfba_pkg::ST_BAD_FREE;
                  state      <= S_OUT;
                end else begin
                  state  <= S_RMRG;
                end
              end
            end
          end
          S_RMRG: begin
            if (rm) begin
              cmd_idx <= hit_idx;
              count   <= count - CW'(1);
            end
            state <= S_LMRG;
          end
          S_LMRG: begin
            if (lm) begin
              cmd_idx <= hit_idx - IW'(1);
              count   <= count - CW'(1);
            end
            state <= S_OUT;
          end
          S_OUT: begin
            if (!response.valid || response.ready) begin
              response.valid         <= 1'b1;
              response.status        <= res_status;
              response.address       <= res_address;
              response.granted_bytes <= res_bytes;
              state                  <= S_IDLE;
            end
          end
          default: begin
            state <= S_INIT;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== verif/bfba_tb_pkg.sv =====
// Segment-table predictor and response checker for the allocator testbench.
`timescale 1ns / 100ps
package bfba_tb_pkg;

  localparam int NSEG   = 64;
  localparam int HDR    = 24;
  localparam int GRAN   = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] address;
    logic [20:0] granted;
  } grant_t;

  class alloc_scoreboard;
    longint seg_start[NSEG];
    longint seg_bytes[NSEG];
    bit     seg_free[NSEG];
    int     seg_count;
    longint arena;
    grant_t pending_grants[$];
    int     mismatches;

    function new();
      mismatches = 0;
      arena = 65536;
      rebuild();
    endfunction

    function void rebuild();
      for (int i = 0; i < NSEG; i++) begin
        seg_start[i] = 0;
        seg_bytes[i] = 0;
        seg_free[i] = 0;
      end
      seg_bytes[0] = (arena >= HDR) ? arena - HDR : 0;
      seg_free[0] = 1;
      seg_count = 1;
    endfunction

    function void set_arena(logic [20:0] v);
      longint a;
      a = v;
      if (a < 64) a = 64;
      if (a > 1048576) a = 1048576;
      arena = a;
      rebuild();
    endfunction

    function void drop_entry(int idx);
      for (int i = idx; i + 1 < seg_count; i++) begin
        seg_start[i] = seg_start[i+1];
        seg_bytes[i] = seg_bytes[i+1];
        seg_free[i] = seg_free[i+1];
      end
      seg_count--;
      seg_start[seg_count] = 0;
      seg_bytes[seg_count] = 0;
      seg_free[seg_count] = 0;
    endfunction

    function bit touching(int a, int b);
      return seg_start[a] + HDR + seg_bytes[a] == seg_start[b];
    endfunction

    // note an accepted request and queue its response
    function void note_request(logic kind, logic [20:0] req, logic [19:0] addr);
      grant_t g;
      longint want, rem;
      int best, idx;
      bit found;
      g = '0;
      if (kind == bfba_pkg::KIND_ALLOC) begin
        if (req == 0) g.status = bfba_pkg::ST_ZERO;
        else begin
          want = (longint'(req) + GRAN - 1) / GRAN * GRAN;
          found = 0;
          best = 0;
          for (int i = 0; i < seg_count; i++)
            if (seg_free[i] && seg_bytes[i] >= want &&
                (!found || seg_bytes[i] < seg_bytes[best])) begin
              best = i;
              found = 1;
            end
          if (!found) g.status = bfba_pkg::ST_NO_FIT;
          else begin
            rem = seg_bytes[best] - want;
            if (rem >= HDR + GRAN && seg_count < NSEG) begin
              for (int i = seg_count; i > best + 1; i--) begin
                seg_start[i] = seg_start[i-1];
                seg_bytes[i] = seg_bytes[i-1];
                seg_free[i] = seg_free[i-1];
              end
              seg_start[best+1] = seg_start[best] + HDR + want;
              seg_bytes[best+1] = rem - HDR;
              seg_free[best+1] = 1;
              seg_bytes[best] = want;
              seg_count++;
            end
            seg_free[best] = 0;
            g.address = 20'(seg_start[best] + HDR);
            g.granted = 21'(seg_bytes[best]);
          end
        end
      end else begin
        idx = -1;
        for (int i = 0; i < seg_count; i++)
          if (idx < 0 && seg_start[i] + HDR == addr && !seg_free[i]) idx = i;
        if (idx < 0) g.status = bfba_pkg::ST_BAD_FREE;
        else begin
          seg_free[idx] = 1;
          if (idx + 1 < seg_count && seg_free[idx+1] && touching(idx, idx + 1)) begin
            seg_bytes[idx] += HDR + seg_bytes[idx+1];
            drop_entry(idx + 1);
          end
          if (idx > 0 && seg_free[idx-1] && touching(idx - 1, idx)) begin
            seg_bytes[idx-1] += HDR + seg_bytes[idx];
            drop_entry(idx);
          end
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void check_response(grant_t got);
      grant_t exp;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      exp = pending_grants.pop_front();
      if (exp.status !== got.status || exp.address !== got.address ||
          exp.granted !== got.granted) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: exp st=%0d a=%0h g=%0d got st=%0d a=%0h g=%0d",
                   exp.status, exp.address, exp.granted,
                   got.status, got.address, got.granted);
      end
    endfunction
  endclass
endpackage

// ===== verif/testbench.sv =====
// Top level of the allocator testbench: clock, reset, request driver and checker.
`timescale 1ns / 100ps
module testbench;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write_en = 0;
  logic [20:0] cfg_write_data = '0;

  bfba_req_if #(.ADDR_BITS(20)) req_ch ();
  bfba_rsp_if #(.ADDR_BITS(20)) rsp_ch ();

  best_fit_block_allocator i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .request        (req_ch.sink),
    .response       (rsp_ch.source)
  );

  always #4 clk = ~clk;

  bfba_tb_pkg::alloc_scoreboard board = new();

  // idling is switched off for a calm stretch in the middle of the run
  bit calm = 0;
  // live allocations, so that most frees hit real blocks
  logic [19:0] held_blocks[$];

  // receiver: random stalls, every word compared on arrival
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        board.check_response({rsp_ch.status, rsp_ch.address, rsp_ch.granted_bytes});
        if (rsp_ch.status == bfba_pkg::ST_OK && rsp_ch.granted_bytes != 0)
          held_blocks.push_back(rsp_ch.address);
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // one request word; held until accepted, then noted in the predictor
  task automatic send_word(logic kind, logic [20:0] req, logic [19:0] addr);
    while (!calm && $urandom_range(99) < 19) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.kind <= kind;
    req_ch.request_bytes <= req;
    req_ch.block_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(kind, req, addr);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (board.pending_grants.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // reconfigure only once the table is idle
  task automatic write_arena(logic [20:0] v);
    drain();
    cfg_write_en <= 1;
    cfg_write_data <= v;
    @(posedge clk);
    board.set_arena(v);
    cfg_write_en <= 0;
    @(posedge clk);
  endtask

  // free a held block, mostly; sometimes a stale or random address
  task automatic send_free();
    int k;
    logic [19:0] a;
    if (held_blocks.size() != 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(held_blocks.size() - 1);
      a = held_blocks[k];
      if ($urandom_range(9) != 0) held_blocks.delete(k);  // else double free later
    end else a = 20'($urandom);
    send_word(bfba_pkg::KIND_FREE, '0, a);
  endtask

  task automatic random_phase(int count, int top);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1)) send_free();
      else if ($urandom_range(19) == 0)
        send_word(bfba_pkg::KIND_ALLOC, 21'($urandom), 20'($urandom));
      else send_word(bfba_pkg::KIND_ALLOC, 21'($urandom_range(top)), 20'($urandom));
    end
  endtask

  initial begin
    req_ch.valid = 0;
    req_ch.kind = bfba_pkg::KIND_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.block_address = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // directed: size extremes, zero size, no fit, bad and double frees
    send_word(bfba_pkg::KIND_ALLOC, 21'd0, 20'hFFFFF);
    send_word(bfba_pkg::KIND_ALLOC, 21'd1, 20'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'h1FFFFF, 20'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'd1048576, 20'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'd16, 20'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'd17, 20'd0);
    send_word(bfba_pkg::KIND_FREE, 21'h1FFFFF, 20'd24);
    send_word(bfba_pkg::KIND_FREE, 21'd0, 20'd24);
    send_word(bfba_pkg::KIND_FREE, 21'd0, 20'hFFFFF);
    send_word(bfba_pkg::KIND_FREE, 21'd0, 20'd64);
    send_word(bfba_pkg::KIND_ALLOC, 21'd65512 - 21'd80, 20'd0);
    drain();
    held_blocks.delete();

    // a clamped-low value, then the smallest arena
    write_arena(21'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'd40, 20'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'd41, 20'd0);
    send_word(bfba_pkg::KIND_FREE, 21'd0, 20'd24);
    send_word(bfba_pkg::KIND_ALLOC, 21'd1, 20'd0);
    write_arena(21'd64);
    send_word(bfba_pkg::KIND_ALLOC, 21'd16, 20'd0);
    send_word(bfba_pkg::KIND_ALLOC, 21'd16, 20'd0);
    drain();
    held_blocks.delete();

    // full table: many tiny grants, then a random mix of frees and grants to exercise merging
    write_arena(21'd8192);
    for (int n = 0; n < 70; n++)
      send_word(bfba_pkg::KIND_ALLOC, 21'($urandom_range(1, 48)), '0);
    drain();
    random_phase(200, 200);
    drain();
    held_blocks.delete();

    // largest arena, clamped from above
    write_arena(21'h1FFFFF);
    random_phase(300, 40000);
    // the sender holds off until all responses are back
    drain();
    calm = 1;
    random_phase(250, 40000);
    calm = 0;
    drain();
    held_blocks.delete();

    write_arena(21'd1048576);
    random_phase(300, 70000);
    drain();
    held_blocks.delete();

    write_arena(21'($urandom_range(64, 4096)));
    random_phase(450, 300);
    drain();

    if (board.mismatches == 0 && board.pending_grants.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/bfba_pkg.sv
hw/rtl/bfba_if.sv
hw/rtl/bfba_cell.sv
hw/rtl/best_fit_block_allocator.sv
verif/bfba_tb_pkg.sv
verif/testbench.sv
